### design/keyed_record_table_top_macros.svh
// ----------------------------------------------------------------------------
// keyed record table assertion macros
// shared wrappers for the concurrent checks of the table logic
// ----------------------------------------------------------------------------
`ifndef KEYED_RECORD_TABLE_TOP_MACROS_SVH
`define KEYED_RECORD_TABLE_TOP_MACROS_SVH

// check that is switched off while reset is asserted
`define KRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that also holds while reset is asserted
`define KRT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### design/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg
// types and codes shared by the keyed record table and its cells
// ----------------------------------------------------------------------------
package krt_pkg;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_ADDED     = 3'd2,
    ST_UPDATED   = 3'd3,
    ST_FULL      = 3'd4,
    ST_REMOVED   = 3'd5,
    ST_CLEARED   = 3'd6
  } status_e;

  // register word index on the config port
  localparam logic REG_CAPACITY = 1'b0;

  localparam int unsigned CAP_W     = 7;
  localparam int unsigned OUT_IDX_W = 6;
  localparam int unsigned OUT_CNT_W = 7;
  localparam logic [CAP_W-1:0] CAPACITY_RST = 7'd64;

  // command broadcast to every cell
  typedef struct packed {
    logic        cmp_en;
    logic        wr_hit;
    logic        append;
    logic        shift;
    logic [31:0] key;
    logic [31:0] value;
  } cell_cmd_t;

endpackage

### design/keyed_record_table_top.sv
// ----------------------------------------------------------------------------
// keyed_record_table_top
// packed key/value table with lookup, add or update, ordered remove and clear
// ----------------------------------------------------------------------------
// Each request passes a compare phase and an update phase. In the compare
// phase all DEPTH cells compare the key in parallel into a registered match
// vector; in the update phase the hit index and value are resolved and the
// write, append or one-step shift of the cells is applied. The update phase
// stalls while the result register is full and not taken; the next request
// is taken as it completes. The result is held in an output register until
// it is taken downstream.
`include "keyed_record_table_top_macros.svh"

module keyed_record_table_top #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // key[31:0], value[63:32]
  input  logic [1:0]  s_axis_tuser,  // func[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // status[2:0], entry_index[8:3],
                                     // entry_value[40:9], used_count[47:41]
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import krt_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CMP,
    PH_UPD
  } phase_e;

  phase_e               phase_q;
  logic [CAP_W-1:0]     capacity_q;
  logic [CW-1:0]        count_q;
  logic [CW-1:0]        count_d;
  func_e                func_q;
  logic [31:0]          key_q;
  logic [31:0]          value_q;

  logic                 out_vld_q;
  status_e              status_q;
  logic [OUT_IDX_W-1:0] idx_q;
  logic [31:0]          val_q;
  logic [OUT_CNT_W-1:0] used_q;

  logic                 in_accept;
  logic                 upd_fire;
  cell_cmd_t            cmd;

  logic [DEPTH-1:0]     match_vec;
  logic [31:0]          cell_key [DEPTH];
  logic [31:0]          cell_val [DEPTH];
  logic [IW-1:0]        hit_idx;
  logic [31:0]          hit_val;
  logic                 hit;

  logic [MW-1:0]        cap_eff;
  logic                 room;
  status_e              status_d;
  logic [IW-1:0]        idx_d;
  logic [31:0]          val_d;
  logic                 cfg_wr;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RST;
    end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
      capacity_q <= pwdata[CAP_W-1:0];
    end
  end

  // ---------------------------------------------------------------- handshake
  assign upd_fire      = (phase_q == PH_UPD) && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = (phase_q == PH_IDLE) || upd_fire;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- cell row
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [31:0] nxt_key;
    logic [31:0] nxt_val;
    if (g < DEPTH - 1) begin : g_mid
      assign nxt_key = cell_key[g+1];
      assign nxt_val = cell_val[g+1];
    end else begin : g_end
      assign nxt_key = cell_key[g];
      assign nxt_val = cell_val[g];
    end
    krt_cell #(
      .INDEX(g),
      .IW   (IW),
      .CW   (CW)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .count_i   (count_q),
      .hit_idx_i (hit_idx),
      .next_key_i(nxt_key),
      .next_val_i(nxt_val),
      .key_o     (cell_key[g]),
      .val_o     (cell_val[g]),
      .match_o   (match_vec[g])
    );
  end

  // keys are unique among valid cells, so at most one match bit is set
  always_comb begin
    hit_idx = '0;
    hit_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_idx = hit_idx | (match_vec[i] ? IW'(i) : IW'(0));
      hit_val = hit_val | (match_vec[i] ? cell_val[i] : 32'd0);
    end
  end
  assign hit = |match_vec;

  // ---------------------------------------------------------------- decision
  assign cap_eff = (MW'(capacity_q) > MW'(DEPTH)) ? MW'(DEPTH) : MW'(capacity_q);
  assign room    = MW'(count_q) < cap_eff;

  always_comb begin
    cmd        = '0;
    cmd.cmp_en = (phase_q == PH_CMP);
    cmd.key    = key_q;
    cmd.value  = value_q;
    status_d   = ST_NOT_FOUND;
    idx_d      = '0;
    val_d      = '0;
    count_d    = count_q;
    unique case (func_q)
      FUNC_LOOKUP: begin
        if (hit) begin
          status_d = ST_FOUND;
          idx_d    = hit_idx;
          val_d    = hit_val;
        end
      end
      FUNC_ADD: begin
        if (hit) begin
          status_d   = ST_UPDATED;
          idx_d      = hit_idx;
          cmd.wr_hit = upd_fire;
        end else if (room) begin
          status_d   = ST_ADDED;
          idx_d      = IW'(count_q);
          cmd.append = upd_fire;
          count_d    = count_q + CW'(1);
        end else begin
          status_d = ST_FULL;
        end
      end
      FUNC_REMOVE: begin
        if (hit) begin
          status_d  = ST_REMOVED;
          idx_d     = hit_idx;
          cmd.shift = upd_fire;
          count_d   = count_q - CW'(1);
        end
      end
      FUNC_CLEAR: begin
        status_d = ST_CLEARED;
        count_d  = '0;
      end
      default: begin
        status_d = ST_NOT_FOUND;
      end
    endcase
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      unique case (phase_q)
        PH_IDLE: if (in_accept) phase_q <= PH_CMP;
        PH_CMP:  phase_q <= PH_UPD;
        PH_UPD: begin
          if (upd_fire) phase_q <= in_accept ? PH_CMP : PH_IDLE;
        end
        default: phase_q <= PH_IDLE;
      endcase
      if (upd_fire) begin
        count_q   <= count_d;
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q  <= func_e'(s_axis_tuser);
      key_q   <= s_axis_tdata[31:0];
      value_q <= s_axis_tdata[63:32];
    end
    if (upd_fire) begin
      status_q <= status_d;
      idx_q    <= OUT_IDX_W'(idx_d);
      val_q    <= val_d;
      used_q   <= OUT_CNT_W'(count_d);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {used_q, val_q, idx_q, status_q};

  // ---------------------------------------------------------------- checks
  `KRT_ASSERT(a_match_unique, (phase_q == PH_UPD) |-> $onehot0(match_vec),
    "more than one cell matches the request key")
  `KRT_ASSERT(a_count_bound, count_q <= CW'(DEPTH),
    "entry count exceeds table depth")
  `KRT_ASSERT(a_upd_gives_result, upd_fire |=> m_axis_tvalid,
    "update cycle did not produce a result")
  `KRT_ASSERT(a_accept_to_cmp, in_accept |=> (phase_q == PH_CMP),
    "accepted request did not move to compare")
  `KRT_ASSERT_RST(a_rst_no_result, !rst_ni |=> !m_axis_tvalid,
    "result valid while in reset")

endmodule

### design/krt_cell.sv
// ----------------------------------------------------------------------------
// krt_cell
// one table entry: key and value storage, key compare, shift from neighbor
// ----------------------------------------------------------------------------
module krt_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned IW    = 6,
  parameter int unsigned CW    = 7
) (
  input  logic              clk_i,
  input  krt_pkg::cell_cmd_t cmd_i,
  input  logic [CW-1:0]     count_i,
  input  logic [IW-1:0]     hit_idx_i,
  input  logic [31:0]       next_key_i,
  input  logic [31:0]       next_val_i,
  output logic [31:0]       key_o,
  output logic [31:0]       val_o,
  output logic              match_o
);
  import krt_pkg::*;

  logic [31:0] key_q;
  logic [31:0] val_q;
  logic        match_q;
  logic        valid;

  assign valid = count_i > CW'(INDEX);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_en) begin
      match_q <= valid && (key_q == cmd_i.key);
    end
    if (cmd_i.append && (count_i == CW'(INDEX))) begin
      key_q <= cmd_i.key;
      val_q <= cmd_i.value;
    end else if (cmd_i.shift && (hit_idx_i <= IW'(INDEX))) begin
      // close the gap left by the removed entry
      key_q <= next_key_i;
      val_q <= next_val_i;
    end else if (cmd_i.wr_hit && match_q) begin
      val_q <= cmd_i.value;
    end
  end

  assign key_o   = key_q;
  assign val_o   = val_q;
  assign match_o = match_q;

endmodule

### tb/keyed_record_table_top_tb.sv
// ----------------------------------------------------------------------------
// keyed_record_table_top_tb
// drives lookup, add, remove and clear requests into the key/value table,
// checks every result against a behavioral table model or a literal row's result,
// across several capacity settings, with random gaps and one long output stall
// ----------------------------------------------------------------------------
module keyed_record_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import krt_pkg::*;

  localparam int DEPTH     = 64;
  localparam int POOL_SIZE = 80;
  localparam logic [2:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

  typedef struct packed {
    status_e     status;
    logic [5:0]  idx;
    logic [31:0] value;
    logic [6:0]  count;
  } table_result_t;

  typedef struct {
    bit            is_cfg;
    int            cap;
    func_e         func;
    logic [31:0]   key;
    logic [31:0]   data;
    bit            lit;
    table_result_t res;
  } dir_row_t;

  typedef struct {
    int cap;
    int n;
    int add_pct;
    int rm_pct;
    int clr_pct;
  } phase_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // key[31:0], value[63:32]
  logic [1:0]  s_axis_tuser;   // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // status[2:0], entry_index[8:3], entry_value[40:9],
                               // used_count[47:41]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // behavioral copy of the table
  logic [31:0] tbl_keys [DEPTH];
  logic [31:0] tbl_vals [DEPTH];
  int          tbl_count;
  int          tbl_cap;

  table_result_t pending_results[$];
  dir_row_t      dir_rows[$];
  logic [31:0]   key_pool [POOL_SIZE];

  int fail_cnt;
  int req_count;
  bit no_gaps;
  bit pressure_done;
  int hold_left;

  keyed_record_table_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic table_result_t table_step(func_e f, logic [31:0] k, logic [31:0] v);
    table_result_t r;
    int hit;
    int lim;
    r.status = ST_NOT_FOUND;
    r.idx    = '0;
    r.value  = '0;
    lim = (tbl_cap > DEPTH) ? DEPTH : tbl_cap;
    hit = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (hit < 0 && tbl_keys[i] == k) hit = i;
    end
    case (f)
      FUNC_LOOKUP: begin
        if (hit >= 0) begin
          r.status = ST_FOUND;
          r.idx    = 6'(hit);
          r.value  = tbl_vals[hit];
        end
      end
      FUNC_ADD: begin
        if (hit >= 0) begin
          tbl_vals[hit] = v;
          r.status = ST_UPDATED;
          r.idx    = 6'(hit);
        end else if (tbl_count < lim) begin
          tbl_keys[tbl_count] = k;
          tbl_vals[tbl_count] = v;
          r.status = ST_ADDED;
          r.idx    = 6'(tbl_count);
          tbl_count++;
        end else begin
          r.status = ST_FULL;
        end
      end
      FUNC_REMOVE: begin
        if (hit >= 0) begin
          // later entries move down one place
          for (int j = hit; j < tbl_count - 1; j++) begin
            tbl_keys[j] = tbl_keys[j+1];
            tbl_vals[j] = tbl_vals[j+1];
          end
          tbl_count--;
          r.status = ST_REMOVED;
          r.idx    = 6'(hit);
        end
      end
      default: begin
        tbl_count = 0;
        r.status  = ST_CLEARED;
      end
    endcase
    r.count = 7'(tbl_count);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic func_e pick_func(phase_t ph);
    int r;
    r = $urandom_range(0, 99);
    if (r < ph.add_pct) return FUNC_ADD;
    if (r < ph.add_pct + ph.rm_pct) return FUNC_REMOVE;
    if (r < ph.add_pct + ph.rm_pct + ph.clr_pct) return FUNC_CLEAR;
    return FUNC_LOOKUP;
  endfunction

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic void push_op(func_e f, logic [31:0] k, logic [31:0] v);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.cap    = 0;
    row.func   = f;
    row.key    = k;
    row.data   = v;
    row.lit    = 1'b0;
    row.res    = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void push_lit(func_e f, logic [31:0] k, logic [31:0] v, status_e st,
                                   logic [5:0] idx, logic [31:0] val, logic [6:0] cnt);
    dir_row_t row;
    row.is_cfg     = 1'b0;
    row.cap        = 0;
    row.func       = f;
    row.key        = k;
    row.data       = v;
    row.lit        = 1'b1;
    row.res.status = st;
    row.res.idx    = idx;
    row.res.value  = val;
    row.res.count  = cnt;
    dir_rows.push_back(row);
  endfunction

  function automatic void push_cfg(int cap);
    dir_row_t row;
    row.is_cfg = 1'b1;
    row.cap    = cap;
    row.func   = FUNC_LOOKUP;
    row.key    = '0;
    row.data   = '0;
    row.lit    = 1'b0;
    row.res    = '0;
    dir_rows.push_back(row);
  endfunction

  // returns the table model's result so that literal rows can override it
  task automatic send_request(func_e f, logic [31:0] k, logic [31:0] v,
                              output table_result_t res);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {v, k};
    do @(posedge clk_i); while (!s_axis_tready);
    res = table_step(f, k, v);
    req_count++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic read_capacity();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CAPACITY_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(tbl_cap)) begin
      $error("capacity: expected %0d, actual %0d", tbl_cap, prdata);
      fail_cnt++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_capacity(int cap);
    wait_drained();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= 32'(cap);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tbl_cap = cap & 32'h7f;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    read_capacity();
  endtask

  // output side: random ready gaps plus one long hold-off
  initial begin
    m_axis_tready = 1'b0;
    hold_left     = 0;
    pressure_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!pressure_done && req_count >= 333) begin
        hold_left     = 300;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        hold_left = pick_gap();
        m_axis_tready <= (hold_left == 0);
        if (hold_left > 0) hold_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %h", m_axis_tdata);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[2:0] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_axis_tdata[2:0]);
          fail_cnt++;
        end
        if (m_axis_tdata[8:3] !== want.idx) begin
          $error("entry_index: expected %0d, actual %0d", want.idx, m_axis_tdata[8:3]);
          fail_cnt++;
        end
        if (m_axis_tdata[40:9] !== want.value) begin
          $error("entry_value: expected %h, actual %h", want.value, m_axis_tdata[40:9]);
          fail_cnt++;
        end
        if (m_axis_tdata[47:41] !== want.count) begin
          $error("used_count: expected %0d, actual %0d", want.count, m_axis_tdata[47:41]);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    phase_t phases [8];
    dir_row_t row;
    table_result_t res;
    func_e f;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    fail_cnt      = 0;
    req_count     = 0;
    no_gaps       = 1'b0;
    tbl_count     = 0;
    tbl_cap       = 64;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_keys[i] = '0;
      tbl_vals[i] = '0;
    end
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    phases = '{'{127, 110, 70, 8, 0}, '{64, 80, 40, 25, 2}, '{3, 80, 40, 30, 2},
               '{0, 70, 40, 30, 3}, '{100, 100, 65, 10, 1}, '{40, 90, 45, 25, 3},
               '{1, 70, 45, 25, 5}, '{64, 100, 60, 15, 2}};

    // empty table, then the signed extremes as keys and values
    push_lit(FUNC_LOOKUP, 32'h8000_0000, 32'h0, ST_NOT_FOUND, 6'd0, 32'h0, 7'd0);
    push_lit(FUNC_REMOVE, 32'h8000_0000, 32'h0, ST_NOT_FOUND, 6'd0, 32'h0, 7'd0);
    push_lit(FUNC_CLEAR,  32'h0, 32'hffff_ffff, ST_CLEARED, 6'd0, 32'h0, 7'd0);
    push_lit(FUNC_ADD, 32'h8000_0000, 32'h7fff_ffff, ST_ADDED, 6'd0, 32'h0, 7'd1);
    push_lit(FUNC_ADD, 32'h7fff_ffff, 32'h8000_0000, ST_ADDED, 6'd1, 32'h0, 7'd2);
    push_op(FUNC_ADD, 32'h0, 32'h0);
    push_op(FUNC_ADD, 32'hffff_ffff, 32'hffff_ffff);
    push_lit(FUNC_LOOKUP, 32'h8000_0000, 32'h0, ST_FOUND, 6'd0, 32'h7fff_ffff, 7'd4);
    push_lit(FUNC_LOOKUP, 32'h7fff_ffff, 32'h0, ST_FOUND, 6'd1, 32'h8000_0000, 7'd4);
    push_op(FUNC_ADD, 32'h0, 32'h5a5a_a5a5);
    push_op(FUNC_LOOKUP, 32'h0, 32'h0);
    push_op(FUNC_LOOKUP, 32'h1234_5678, 32'h0);
    push_op(FUNC_REMOVE, 32'h1234_5678, 32'h0);
    // remove of the first entry shifts the rest down
    push_op(FUNC_REMOVE, 32'h8000_0000, 32'h0);
    push_op(FUNC_LOOKUP, 32'h7fff_ffff, 32'h0);
    push_op(FUNC_REMOVE, 32'hffff_ffff, 32'h0);
    push_op(FUNC_LOOKUP, 32'hffff_ffff, 32'h0);
    // zero capacity: new keys are refused, updates still land
    push_cfg(0);
    push_lit(FUNC_ADD, 32'h0bad_f00d, 32'h1, ST_FULL, 6'd0, 32'h0, 7'd2);
    push_op(FUNC_ADD, 32'h0, 32'h1);
    push_cfg(2);
    push_op(FUNC_REMOVE, 32'h0, 32'h0);
    push_op(FUNC_ADD, 32'h0bad_f00d, 32'h7);
    push_op(FUNC_ADD, 32'h1, 32'h2);
    // count now above capacity
    push_cfg(1);
    push_op(FUNC_LOOKUP, 32'h0bad_f00d, 32'h0);
    push_lit(FUNC_CLEAR, 32'h0, 32'h0, ST_CLEARED, 6'd0, 32'h0, 7'd0);
    push_op(FUNC_ADD, 32'h1, 32'h2);
    push_lit(FUNC_ADD, 32'h2, 32'h3, ST_FULL, 6'd0, 32'h0, 7'd1);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    read_capacity();

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        set_capacity(row.cap);
      end else begin
        send_request(row.func, row.key, row.data, res);
        pending_results.push_back(row.lit ? row.res : res);
      end
    end

    foreach (phases[p]) begin
      set_capacity(phases[p].cap);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < phases[p].n; n++) begin
        f = pick_func(phases[p]);
        send_request(f, pick_key(), $urandom, res);
        pending_results.push_back(res);
      end
    end
    no_gaps = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/krt_pkg.sv
design/krt_cell.sv
design/keyed_record_table_top.sv
tb/keyed_record_table_top_tb.sv
